// ===== hdl/stb_pkg.sv =====
// Shared types and constants of the software timer bank.
// Holds sizes, operation and result codes, sequencer states and transaction structs.
// No dependencies; every other file in hdl/ uses it by scoped names.
package stb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int ID_W        = 4;                         // timer id field width
    localparam int TICKS_W     = 32;                        // ticks field width
    localparam int IDX_W       = $clog2(NUM_TIMERS);        // store index width
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);    // holds 0..NUM_TIMERS

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_ID      = 2'd0,
        KIND_REFUSED = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_NOTICE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [ID_W-1:0]    timer_id;
        logic [TICKS_W-1:0] ticks;
        logic               periodic;
        logic               notify;
    } cmd_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] result_id;
        logic            expired_flag;
        logic            last;
    } rsp_t;

    // Count/period store access from the sequencer
    typedef struct packed {
        logic                   we;      // write count at waddr
        logic                   load;    // also write period (start)
        logic [IDX_W-1:0]       waddr;
        logic [IDX_W-1:0]       raddr;
        logic [COUNT_WIDTH-1:0] wdata;
    } mem_req_t;

endpackage

// ===== hdl/stb_mem.sv =====
// Count and period stores of the timer bank, one write and one registered read port each.
// Depends on stb_pkg.
module stb_mem
(
    input  logic                           clk,
    input  stb_pkg::mem_req_t              mem_req,
    output logic [stb_pkg::COUNT_WIDTH-1:0] rd_count,
    output logic [stb_pkg::COUNT_WIDTH-1:0] rd_period
);

    logic [stb_pkg::COUNT_WIDTH-1:0] count_mem  [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::COUNT_WIDTH-1:0] period_mem [stb_pkg::NUM_TIMERS];

    // Writes
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            count_mem[mem_req.waddr] <= mem_req.wdata;
            if (mem_req.load)
            begin
                period_mem[mem_req.waddr] <= mem_req.wdata;
            end
        end
    end

    // Registered reads
    always_ff @(posedge clk)
    begin
        rd_count  <= count_mem[mem_req.raddr];
        rd_period <= period_mem[mem_req.raddr];
    end

endmodule

// ===== hdl/stb_ctrl.sv =====
// Sequencer of the timer bank: command decode, timer marks, shared decrement unit,
// pending-notice hold and the result register.
// Depends on stb_pkg; drives the stores in stb_mem.
module stb_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  stb_pkg::cmd_t                   cmd,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output stb_pkg::rsp_t                   rsp,
    output stb_pkg::mem_req_t               mem_req,
    input  logic [stb_pkg::COUNT_WIDTH-1:0] rd_count,
    input  logic [stb_pkg::COUNT_WIDTH-1:0] rd_period
);

    stb_pkg::state_t                state_reg, state_next;
    logic [stb_pkg::CNT_W-1:0]      t_reg, t_next;
    logic [stb_pkg::CNT_W-1:0]      alloc_reg, alloc_next;
    logic [stb_pkg::NUM_TIMERS-1:0] running_reg, running_next;
    logic [stb_pkg::NUM_TIMERS-1:0] expired_reg, expired_next;
    logic [stb_pkg::NUM_TIMERS-1:0] periodic_reg, periodic_next;
    logic [stb_pkg::NUM_TIMERS-1:0] notify_reg, notify_next;
    logic                           pend_vld_reg, pend_vld_next;
    logic [stb_pkg::IDX_W-1:0]      pend_id_reg, pend_id_next;
    logic                           out_vld_reg, out_vld_next;
    stb_pkg::rsp_t                  out_reg, out_next;

    logic                           out_free;
    logic                           accept;
    logic [stb_pkg::IDX_W-1:0]      cmd_idx;
    logic [stb_pkg::IDX_W-1:0]      idx;
    logic [stb_pkg::COUNT_WIDTH-1:0] dec;
    logic                           hit;
    logic                           notice;
    logic                           blocked;

    assign out_free  = !out_vld_reg || !rsp_stall;
    assign cmd_stall = (state_reg != stb_pkg::ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_idx   = stb_pkg::IDX_W'(cmd.timer_id);
    assign idx       = t_reg[stb_pkg::IDX_W-1:0];

    // Shared decrement and zero compare
    assign dec     = rd_count - stb_pkg::COUNT_WIDTH'(1);
    assign hit     = (dec == '0);
    assign notice  = running_reg[idx] && hit && notify_reg[idx];
    assign blocked = notice && pend_vld_reg && !out_free;

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        alloc_next    = alloc_reg;
        running_next  = running_reg;
        expired_next  = expired_reg;
        periodic_next = periodic_reg;
        notify_next   = notify_reg;
        pend_vld_next = pend_vld_reg;
        pend_id_next  = pend_id_reg;
        out_vld_next  = out_vld_reg && rsp_stall;
        out_next      = out_reg;
        mem_req       = '0;
        mem_req.raddr = idx;

        unique case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.operation)
                        stb_pkg::OP_TICK:
                        begin
                            t_next        = '0;
                            pend_vld_next = 1'b0;
                            state_next    = stb_pkg::ST_READ;
                        end
                        stb_pkg::OP_ALLOC:
                        begin
                            out_vld_next          = 1'b1;
                            out_next.expired_flag = 1'b0;
                            out_next.last         = 1'b1;
                            if (alloc_reg >= stb_pkg::CNT_W'(stb_pkg::NUM_TIMERS))
                            begin
                                out_next.kind      = stb_pkg::KIND_REFUSED;
                                out_next.result_id = '0;
                            end
                            else
                            begin
                                out_next.kind      = stb_pkg::KIND_ID;
                                out_next.result_id = stb_pkg::ID_W'(alloc_reg);
                                alloc_next         = alloc_reg + 1'b1;
                            end
                        end
                        stb_pkg::OP_START:
                        begin
                            if (stb_pkg::CNT_W'(cmd.timer_id) < alloc_reg)
                            begin
                                mem_req.we             = 1'b1;
                                mem_req.load           = 1'b1;
                                mem_req.waddr          = cmd_idx;
                                mem_req.wdata          = stb_pkg::COUNT_WIDTH'(cmd.ticks);
                                periodic_next[cmd_idx] = cmd.periodic;
                                notify_next[cmd_idx]   = cmd.notify;
                                expired_next[cmd_idx]  = 1'b0;
                                running_next[cmd_idx]  = 1'b1;
                            end
                        end
                        stb_pkg::OP_STOP:
                        begin
                            running_next[cmd_idx] = 1'b0;
                            expired_next[cmd_idx] = 1'b0;
                        end
                        stb_pkg::OP_QUERY:
                        begin
                            out_vld_next          = 1'b1;
                            out_next.kind         = stb_pkg::KIND_QUERY;
                            out_next.result_id    = cmd.timer_id;
                            out_next.expired_flag = expired_reg[cmd_idx];
                            out_next.last         = 1'b1;
                            expired_next[cmd_idx] = 1'b0;
                        end
                        default:
                        begin
                            // unused codes: no effect
                        end
                    endcase
                end
            end

            // Read slot: address t is presented to the stores
            stb_pkg::ST_READ:
            begin
                if (t_reg >= alloc_reg)
                begin
                    state_next = stb_pkg::ST_FLUSH;
                end
                else
                begin
                    state_next = stb_pkg::ST_EXEC;
                end
            end

            // Execute slot: decrement, reload or stop, hold notice
            stb_pkg::ST_EXEC:
            begin
                if (!blocked)
                begin
                    if (running_reg[idx])
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = idx;
                        mem_req.wdata = (hit && periodic_reg[idx]) ? rd_period : dec;
                        if (hit)
                        begin
                            expired_next[idx] = 1'b1;
                            if (!periodic_reg[idx])
                            begin
                                running_next[idx] = 1'b0;
                            end
                        end
                    end
                    if (notice)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next          = 1'b1;
                            out_next.kind         = stb_pkg::KIND_NOTICE;
                            out_next.result_id    = stb_pkg::ID_W'(pend_id_reg);
                            out_next.expired_flag = 1'b0;
                            out_next.last         = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_id_next  = idx;
                    end
                    t_next     = t_reg + 1'b1;
                    state_next = stb_pkg::ST_READ;
                end
            end

            // End of tick: release the held notice as the last one
            stb_pkg::ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = stb_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next          = 1'b1;
                    out_next.kind         = stb_pkg::KIND_NOTICE;
                    out_next.result_id    = stb_pkg::ID_W'(pend_id_reg);
                    out_next.expired_flag = 1'b0;
                    out_next.last         = 1'b1;
                    pend_vld_next         = 1'b0;
                    state_next            = stb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stb_pkg::ST_IDLE;
            t_reg        <= '0;
            alloc_reg    <= stb_pkg::CNT_W'(1);
            running_reg  <= '0;
            expired_reg  <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            t_reg        <= t_next;
            alloc_reg    <= alloc_next;
            running_reg  <= running_next;
            expired_reg  <= expired_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        periodic_reg <= periodic_next;
        notify_reg   <= notify_next;
        pend_id_reg  <= pend_id_next;
        out_reg      <= out_next;
    end

endmodule

// ===== hdl/software_timer_bank.sv =====
// Bank of down-counting timers: top level, sequencer plus count/period stores.
// Allocate, start, stop and query are handled in the idle state; a tick is swept by one decrement
// unit visiting each allocated timer through a read slot and an execute slot.
// A result register held by rsp_stall can hold up a tick sweep. cmd_stall is high meanwhile.
// Reset: running and expired marks cleared, allocation count one; stores undefined until started.
// Depends on stb_pkg, stb_mem and stb_ctrl.
module software_timer_bank
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  stb_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stb_pkg::rsp_t rsp
);

    stb_pkg::mem_req_t               mem_req;
    logic [stb_pkg::COUNT_WIDTH-1:0] rd_count;
    logic [stb_pkg::COUNT_WIDTH-1:0] rd_period;

    // Sequencer
    stb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .rd_count  (rd_count),
        .rd_period (rd_period)
    );

    // Count and period stores
    stb_mem u_mem
    (
        .clk       (clk),
        .mem_req   (mem_req),
        .rd_count  (rd_count),
        .rd_period (rd_period)
    );

endmodule

// ===== hdl/stb_checker.sv =====
// Port-level checks of the software timer bank, bound to the top level.
// Depends on stb_pkg and software_timer_bank.
module stb_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input stb_pkg::cmd_t cmd,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input stb_pkg::rsp_t rsp
);

    // Held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

    // A query transaction is answered in the next cycle as a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.operation == stb_pkg::OP_QUERY)
        |=> rsp_valid && (rsp.kind == stb_pkg::KIND_QUERY) && rsp.last
            && (rsp.result_id == $past(cmd.timer_id)))
    else $error("query answer missing or wrong");

    // Only query answers carry the expired flag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != stb_pkg::KIND_QUERY) |-> !rsp.expired_flag)
    else $error("expired flag set outside a query answer");

    // Allocation results are single and final; refusal names id zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp.kind == stb_pkg::KIND_ID) || (rsp.kind == stb_pkg::KIND_REFUSED))
        |-> rsp.last && ((rsp.kind == stb_pkg::KIND_ID) || (rsp.result_id == '0)))
    else $error("malformed allocation result");

    // A tick transaction keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.operation == stb_pkg::OP_TICK) |=> cmd_stall)
    else $error("new transaction taken during tick sweep");

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);
